FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the periodic distance block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, switched off while reset is held.
`define PED_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
// Clocked assertion that also holds through reset.
`define PED_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");
`else
`define PED_ASSERT_RST(lbl, clk, rstn, prop)
`define PED_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/ped_pkg.sv
// Package of the periodic Euclidean distance block: widths, constants, types.
// No dependencies; imported by every module of the block.
package ped_pkg;

  localparam int DIMS      = 4;
  localparam int FRAC_BITS = 12;

  localparam int VAL_W  = 24;
  localparam int SUB_W  = VAL_W + 1;
  localparam int DIFF_W = VAL_W;
  localparam int TURN_W = VAL_W + 2;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + $clog2(DIMS);
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int DIST_W = 25;

  localparam int MASK_W     = 4;
  localparam int ADIM_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [TURN_W-1:0] HALF_TURN = TURN_W'(180 * (2 ** FRAC_BITS));
  localparam logic [TURN_W-1:0] FULL_TURN = TURN_W'(360 * (2 ** FRAC_BITS));

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [DIFF_W-1:0]       diff_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [ROOT_W-1:0]       root_t;
  typedef logic [REM_W-1:0]        rem_t;
  typedef logic [DIST_W-1:0]       dist_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  localparam cfg_idx_t REG_PERIODIC_MASK = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ACTIVE_DIMS   = cfg_idx_t'(1);

  localparam logic [ADIM_W-1:0] ACTIVE_DIMS_RST = ADIM_W'(4);
  localparam root_t             DIST_MAX_R      = ROOT_W'(2 ** DIST_W - 1);

  typedef struct packed {
    logic [MASK_W-1:0] periodic_mask;
    logic [ADIM_W-1:0] active_dims;
  } cfg_t;

  // Pipeline control handed to each section: advance enable and incoming valid.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

FILE: rtl/core/ped_diff.sv
// Difference section: per-lane subtract, magnitude and angle wrap, three stages.
// Depends on ped_pkg.
module ped_diff import ped_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  pipe_ctl_t           ctl_i,
  input  cfg_t                cfg_i,
  input  val_t  [DIMS-1:0]    first_i,
  input  val_t  [DIMS-1:0]    second_i,
  output logic                valid_o,
  output diff_t [DIMS-1:0]    diff_o
);

  logic [2:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl_i.en) begin
      v_r <= {v_r[1:0], ctl_i.valid};
    end
  end

  assign valid_o = v_r[2];

  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    logic signed [SUB_W-1:0] sub_nxt, sub_r;
    logic                    per_nxt, per1_r, per2_r;
    diff_t                   mag_nxt, mag_r;
    diff_t                   diff_nxt, diff_r;
    logic [TURN_W-1:0]       mag_ext, wrapped;
    logic                    active;

    assign active = ADIM_W'(d) < cfg_i.active_dims;

    if (d < MASK_W) begin : g_per
      assign per_nxt = cfg_i.periodic_mask[d];
    end else begin : g_noper
      assign per_nxt = 1'b0;
    end

    // Inactive lanes enter as zero and stay zero.
    assign sub_nxt = active ?
      ({first_i[d][VAL_W-1], first_i[d]} - {second_i[d][VAL_W-1], second_i[d]}) : '0;

    assign mag_nxt = sub_r[SUB_W-1] ? DIFF_W'(-sub_r) : DIFF_W'(sub_r);

    assign mag_ext  = TURN_W'(mag_r);
    assign wrapped  = (mag_ext > FULL_TURN) ? (mag_ext - FULL_TURN) : (FULL_TURN - mag_ext);
    assign diff_nxt = (per2_r && (mag_ext > HALF_TURN)) ? DIFF_W'(wrapped) : mag_r;

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        sub_r  <= sub_nxt;
        per1_r <= per_nxt;
        mag_r  <= mag_nxt;
        per2_r <= per1_r;
        diff_r <= diff_nxt;
      end
    end

    assign diff_o[d] = diff_r;
  end

endmodule

FILE: rtl/core/ped_sqsum.sv
// Square and sum section: one multiplier per lane, then a two-level adder tree.
// Depends on ped_pkg.
module ped_sqsum import ped_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pipe_ctl_t         ctl_i,
  input  diff_t [DIMS-1:0]  diff_i,
  output logic              valid_o,
  output sum_t              sum_o
);

  localparam int PAIRS = (DIMS + 1) / 2;

  logic [2:0]          v_r;
  logic [SQ_W-1:0]     sq_r   [DIMS];
  logic [SQ_W:0]       pair_r [PAIRS];
  sum_t                sum_nxt, sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl_i.en) begin
      v_r <= {v_r[1:0], ctl_i.valid};
    end
  end

  for (genvar d = 0; d < DIMS; d++) begin : g_sq
    logic [SQ_W-1:0] sq_nxt;
    assign sq_nxt = SQ_W'(diff_i[d]) * SQ_W'(diff_i[d]);
    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        sq_r[d] <= sq_nxt;
      end
    end
  end

  for (genvar j = 0; j < PAIRS; j++) begin : g_pair
    logic [SQ_W:0] pair_nxt;
    if (2 * j + 1 < DIMS) begin : g_two
      assign pair_nxt = {1'b0, sq_r[2*j]} + {1'b0, sq_r[2*j+1]};
    end else begin : g_one
      assign pair_nxt = {1'b0, sq_r[2*j]};
    end
    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        pair_r[j] <= pair_nxt;
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < PAIRS; j++) begin
      sum_nxt = sum_nxt + SUM_W'(pair_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      sum_r <= sum_nxt;
    end
  end

  assign valid_o = v_r[2];
  assign sum_o   = sum_r;

endmodule

FILE: rtl/core/ped_sqrt.sv
// Floor square root, one result bit per pipeline stage (restoring method).
// Depends on ped_pkg.
module ped_sqrt import ped_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pipe_ctl_t  ctl_i,
  input  sum_t       sum_i,
  output logic       valid_o,
  output root_t      root_o,
  output rem_t       rem_o
);

  localparam int RAD_W = 2 * ROOT_W;

  logic [ROOT_W-1:0] v_r;
  logic [RAD_W-1:0]  rad_r  [ROOT_W-1];
  rem_t              rem_r  [ROOT_W];
  root_t             root_r [ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl_i.en) begin
      v_r <= {v_r[ROOT_W-2:0], ctl_i.valid};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0] rad_p;
    rem_t             rem_p, rem_sh, trial, rem_nxt;
    root_t            root_p, root_nxt;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad_p  = RAD_W'(sum_i);
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh   = {rem_p[ROOT_W-1:0], rad_p[RAD_W-1 -: 2]};
    assign trial    = {root_p, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {root_p[ROOT_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end

    if (k < ROOT_W - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (ctl_i.en) begin
          rad_r[k] <= {rad_p[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign valid_o = v_r[ROOT_W-1];
  assign root_o  = root_r[ROOT_W-1];
  assign rem_o   = rem_r[ROOT_W-1];

endmodule

FILE: rtl/core/periodic_euclidean_distance.sv
// Top level of the periodic Euclidean distance block; register file and pipeline control.
// Depends on ped_pkg, ped_diff, ped_sqsum, ped_sqrt and assert_macros.svh.
//
// Each request carries two vectors of four signed Q11.12 values and yields one
// floor(sqrt(sum of squared differences)) as an unsigned Q.12 distance. A dimension
// whose periodic_mask bit is set is taken as an angle in degrees: a difference
// above 180 becomes |360 - difference|. Only dimensions below active_dims count.
// The block takes one request every clock cycle while the output is not held:
// three stages form the lane differences and the angle wrap, three stages
// square and add them, and 25 stages resolve the square root one bit each. The
// whole pipeline advances as one whenever the output register is empty or being
// read, so a held output freezes every stage and nothing is lost or repeated.
// Registers are written through the cfg_ port (index 0 periodic_mask, index 1
// active_dims); cfg_ready is always high, and a write should only be made while
// no request is in flight.
`include "assert_macros.svh"

module periodic_euclidean_distance import ped_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  val_t                  in_first_0,
  input  val_t                  in_first_1,
  input  val_t                  in_first_2,
  input  val_t                  in_first_3,
  input  val_t                  in_second_0,
  input  val_t                  in_second_1,
  input  val_t                  in_second_2,
  input  val_t                  in_second_3,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output dist_t                 out_distance
);

  cfg_t              cfg_r, cfg_nxt;
  logic              pipe_en;
  pipe_ctl_t         diff_ctl, sq_ctl, rt_ctl;
  val_t  [DIMS-1:0]  first_v, second_v;
  diff_t [DIMS-1:0]  diff_v;
  logic              diff_valid, sum_valid;
  sum_t              sum_value;
  root_t             sq_root;
  rem_t              sq_rem, root_x2;

  // Register file: ignore writes to unknown indexes and bits above each field.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PERIODIC_MASK: cfg_nxt.periodic_mask = cfg_wdata[MASK_W-1:0];
        REG_ACTIVE_DIMS:   cfg_nxt.active_dims   = cfg_wdata[ADIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.periodic_mask <= '0;
      cfg_r.active_dims   <= ACTIVE_DIMS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Advance every stage together unless the result in the output register is held.
  assign pipe_en  = !out_valid || out_ready;
  assign in_ready = pipe_en;

  assign diff_ctl = '{en: pipe_en, valid: in_valid};
  assign sq_ctl   = '{en: pipe_en, valid: diff_valid};
  assign rt_ctl   = '{en: pipe_en, valid: sum_valid};

  assign first_v[0]  = in_first_0;
  assign first_v[1]  = in_first_1;
  assign first_v[2]  = in_first_2;
  assign first_v[3]  = in_first_3;
  assign second_v[0] = in_second_0;
  assign second_v[1] = in_second_1;
  assign second_v[2] = in_second_2;
  assign second_v[3] = in_second_3;

  ped_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (diff_ctl),
    .cfg_i    (cfg_r),
    .first_i  (first_v),
    .second_i (second_v),
    .valid_o  (diff_valid),
    .diff_o   (diff_v)
  );

  ped_sqsum u_sqsum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (sq_ctl),
    .diff_i  (diff_v),
    .valid_o (sum_valid),
    .sum_o   (sum_value)
  );

  ped_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (rt_ctl),
    .sum_i   (sum_value),
    .valid_o (out_valid),
    .root_o  (sq_root),
    .rem_o   (sq_rem)
  );

  // Clamp a root that outgrows the result field.
  assign out_distance = (sq_root > DIST_MAX_R) ? DIST_W'(DIST_MAX_R) : DIST_W'(sq_root);

  // Remainder never above twice the root, so the root is the floor.
  assign root_x2 = {1'b0, sq_root, 1'b0};

  `PED_ASSERT_RST(a_root_is_floor, clk, rst_n, out_valid |-> (sq_rem <= root_x2))
  `PED_ASSERT_RST(a_stall_holds_sum, clk, rst_n, !pipe_en |=> $stable(sum_valid) && $stable(sum_value))
  `PED_ASSERT_NR(a_reset_empties_output, clk, !rst_n |=> !out_valid)

endmodule
